// File: rtl/jrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrd_pkg
// Shared types and constants of the radial deadzone pipeline.
// ----------------------------------------------------------------------------
package jrd_pkg;

  localparam int FULL_SCALE = 32768;
  localparam int LOOK_SHIFT = 27;

  localparam logic [14:0] MOVE_DZ_RESET = 15'd8192;
  localparam logic [14:0] LOOK_DZ_RESET = 15'd6554;
  localparam logic [15:0] LOOK_RATE_RESET = 16'd12868;

  typedef enum logic [1:0] {
    REG_MOVE_DZ   = 2'd0,
    REG_LOOK_DZ   = 2'd1,
    REG_LOOK_RATE = 2'd2
  } jrd_reg_t;

  // Sideband that travels with a sample through the arithmetic units.
  typedef struct packed {
    logic        op;
    logic        sx;
    logic        sy;
    logic [14:0] ax;
    logic [14:0] ay;
    logic [14:0] dz;
    logic [31:0] rate;
    logic        pass;
  } jrd_side_t;

endpackage
`default_nettype wire

// File: rtl/jrd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrd channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface jrd_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic [15:0]        frame_time;
  modport source (output valid, operation, axis_x, axis_y, frame_time, input ready);
  modport sink (input valid, operation, axis_x, axis_y, frame_time, output ready);
endinterface

interface jrd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] forward;
  logic signed [15:0] strafe;
  logic signed [20:0] yaw_delta;
  logic signed [20:0] pitch_delta;
  modport source (output valid, forward, strafe, yaw_delta, pitch_delta, input ready);
  modport sink (input valid, forward, strafe, yaw_delta, pitch_delta, output ready);
endinterface

interface jrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/jrd_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrd_isqrt
// Pipelined floor square root of a 32-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module jrd_isqrt #(
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [31:0]   radicand,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_vld,
  output logic [15:0]        root,
  output logic [TW-1:0]      out_tag
);

  logic          vld_w [0:16];
  logic [31:0]   rad_w [0:16];
  logic [18:0]   rem_w [0:16];
  logic [15:0]   root_w [0:16];
  logic [TW-1:0] tag_w [0:16];

  assign vld_w[0]  = in_vld;
  assign rad_w[0]  = radicand;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign tag_w[0]  = in_tag;

  for (genvar i = 0; i < 16; i++) begin : g_stage
    logic          vld_r;
    logic [31:0]   rad_r;
    logic [18:0]   rem_r;
    logic [15:0]   root_r;
    logic [TW-1:0] tag_r;
    logic [18:0]   r2;
    logic [18:0]   trial;
    logic          ge;

    assign r2    = {rem_w[i][16:0], rad_w[i][31:30]};
    assign trial = {1'b0, root_w[i], 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r  <= {rad_w[i][29:0], 2'b00};
        rem_r  <= ge ? (r2 - trial) : r2;
        root_r <= {root_w[i][14:0], ge};
        tag_r  <= tag_w[i];
      end
    end

    assign vld_w[i+1]  = vld_r;
    assign rad_w[i+1]  = rad_r;
    assign rem_w[i+1]  = rem_r;
    assign root_w[i+1] = root_r;
    assign tag_w[i+1]  = tag_r;
  end

  assign out_vld = vld_w[16];
  assign root    = root_w[16];
  assign out_tag = tag_w[16];

endmodule
`default_nettype wire

// File: rtl/jrd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrd_div
// Pipelined restoring divider, one quotient bit per stage. The dividend
// must be below divisor * 2**QW.
// ----------------------------------------------------------------------------
module jrd_div #(
  parameter int NW = 31,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_vld,
  output logic [QW-1:0]      quotient,
  output logic [TW-1:0]      out_tag
);

  localparam int WW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_w [0:QW];
  logic [WW-1:0] rem_w [0:QW];
  logic [DW-1:0] dvs_w [0:QW];
  logic [QW-1:0] q_w [0:QW];
  logic [TW-1:0] tag_w [0:QW];

  assign vld_w[0] = in_vld;
  assign rem_w[0] = WW'(dividend);
  assign dvs_w[0] = divisor;
  assign q_w[0]   = '0;
  assign tag_w[0] = in_tag;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          vld_r;
    logic [WW-1:0] rem_r;
    logic [DW-1:0] dvs_r;
    logic [QW-1:0] q_r;
    logic [TW-1:0] tag_r;
    logic [WW-1:0] trial;
    logic          ge;

    assign trial = WW'(dvs_w[i]) << (QW - 1 - i);
    assign ge    = (rem_w[i] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? (rem_w[i] - trial) : rem_w[i];
        dvs_r <= dvs_w[i];
        q_r   <= {q_w[i][QW-2:0], ge};
        tag_r <= tag_w[i];
      end
    end

    assign vld_w[i+1] = vld_r;
    assign rem_w[i+1] = rem_r;
    assign dvs_w[i+1] = dvs_r;
    assign q_w[i+1]   = q_r;
    assign tag_w[i+1] = tag_r;
  end

  assign out_vld  = vld_w[QW];
  assign quotient = q_w[QW];
  assign out_tag  = tag_w[QW];

endmodule
`default_nettype wire

// File: rtl/joystick_radial_deadzone.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_radial_deadzone
// Scaled radial deadzone for move and look stick samples, fully pipelined.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   in_ch    sink       operation, axis_x, axis_y, frame_time
//   out_ch   source     forward, strafe, yaw_delta, pitch_delta
//   cfg_ch   sink       index, data (move deadzone, look deadzone, look rate)
//
// One sample enters per cycle unless a result waits at out_ch untaken. The
// path runs through the 16-stage square root and two 16-stage dividers in series.
// Reset clears all valid bits and loads the register defaults; cfg_ch is
// always ready. When a result waits at out_ch the whole pipeline holds, and
// in_ch is ready again in the cycle the result transfer completes.
// ----------------------------------------------------------------------------
module joystick_radial_deadzone (
  input  wire logic clk,
  input  wire logic rst_n,
  jrd_in_if.sink    in_ch,
  jrd_out_if.source out_ch,
  jrd_cfg_if.sink   cfg_ch
);

  import jrd_pkg::*;

  // Configuration registers.
  logic [14:0] move_dz_r;
  logic [14:0] look_dz_r;
  logic [15:0] look_rate_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_dz_r   <= MOVE_DZ_RESET;
      look_dz_r   <= LOOK_DZ_RESET;
      look_rate_r <= LOOK_RATE_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MOVE_DZ:   move_dz_r   <= cfg_ch.data[14:0];
        REG_LOOK_DZ:   look_dz_r   <= cfg_ch.data[14:0];
        REG_LOOK_RATE: look_rate_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // The pipeline advances as a whole unless the output holds a result that
  // is not being taken.
  logic out_vld_r;
  logic en;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage A: clamp the axes to sign and magnitude, select the deadzone.
  logic        a_vld_r;
  logic        a_op_r, a_sx_r, a_sy_r;
  logic [14:0] a_ax_r, a_ay_r, a_dz_r;
  logic [15:0] a_lr_r, a_dt_r;
  logic [15:0] neg_x, neg_y;
  logic [14:0] mag_x, mag_y;

  assign neg_x = 16'(-in_ch.axis_x);
  assign neg_y = 16'(-in_ch.axis_y);

  // The most negative code has no positive twin and reads as 15'h7fff.
  always_comb begin
    if (in_ch.axis_x == 16'sh8000) begin
      mag_x = 15'h7fff;
    end else if (in_ch.axis_x[15]) begin
      mag_x = neg_x[14:0];
    end else begin
      mag_x = in_ch.axis_x[14:0];
    end
    if (in_ch.axis_y == 16'sh8000) begin
      mag_y = 15'h7fff;
    end else if (in_ch.axis_y[15]) begin
      mag_y = neg_y[14:0];
    end else begin
      mag_y = in_ch.axis_y[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r <= in_ch.operation;
      a_sx_r <= in_ch.axis_x[15];
      a_sy_r <= in_ch.axis_y[15];
      a_ax_r <= mag_x;
      a_ay_r <= mag_y;
      a_dz_r <= in_ch.operation ? look_dz_r : move_dz_r;
      a_lr_r <= look_rate_r;
      a_dt_r <= in_ch.frame_time;
    end
  end

  // Stage B: squared magnitude, squared deadzone and the look scale factor.
  logic      b_vld_r;
  jrd_side_t b_side_r;
  logic [30:0] b_sq_r;
  logic [29:0] b_dzsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sq_r        <= 31'(a_ax_r) * 31'(a_ax_r) + 31'(a_ay_r) * 31'(a_ay_r);
      b_dzsq_r      <= 30'(a_dz_r) * 30'(a_dz_r);
      b_side_r.op   <= a_op_r;
      b_side_r.sx   <= a_sx_r;
      b_side_r.sy   <= a_sy_r;
      b_side_r.ax   <= a_ax_r;
      b_side_r.ay   <= a_ay_r;
      b_side_r.dz   <= a_dz_r;
      b_side_r.rate <= 32'(a_lr_r) * 32'(a_dt_r);
      b_side_r.pass <= 1'b0;
    end
  end

  // The deadzone test is exact on the squares; a zero sample never passes.
  jrd_side_t b_side;

  always_comb begin
    b_side      = b_side_r;
    b_side.pass = (b_sq_r != 31'd0) && (b_sq_r > 31'(b_dzsq_r));
  end

  logic        sq_vld;
  logic [15:0] sq_root;
  jrd_side_t   sq_side;

  jrd_isqrt #(
    .TW ($bits(jrd_side_t))
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (b_vld_r),
    .radicand (32'(b_sq_r)),
    .in_tag   (b_side),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .out_tag  (sq_side)
  );

  // Stage C: cap the magnitude at full scale and set up the rescale division.
  logic        c_vld_r;
  jrd_side_t   c_side_r;
  logic [15:0] c_mag_r;
  logic [30:0] c_num_r;
  logic [15:0] c_den_r;
  logic [15:0] capped;
  logic [15:0] excess;

  assign capped = (sq_root > 16'(FULL_SCALE)) ? 16'(FULL_SCALE) : sq_root;
  assign excess = (capped > 16'(sq_side.dz)) ? (capped - 16'(sq_side.dz)) : 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= sq_side;
      c_mag_r  <= sq_root;
      c_num_r  <= 31'(excess) << 15;
      c_den_r  <= 16'(FULL_SCALE) - 16'(sq_side.dz);
    end
  end

  logic        s_vld;
  logic [15:0] s_val;
  jrd_side_t   s_side;
  logic [15:0] s_mag;

  jrd_div #(
    .NW (31),
    .DW (16),
    .QW (16),
    .TW ($bits(jrd_side_t) + 16)
  ) u_div_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (c_vld_r),
    .dividend (c_num_r),
    .divisor  (c_den_r),
    .in_tag   ({c_side_r, c_mag_r}),
    .out_vld  (s_vld),
    .quotient (s_val),
    .out_tag  ({s_side, s_mag})
  );

  // Stage D: scale each axis magnitude by the rescaled radius.
  logic        d_vld_r;
  jrd_side_t   d_side_r;
  logic [15:0] d_mag_r;
  logic [30:0] d_px_r, d_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side_r <= s_side;
      d_mag_r  <= s_mag;
      d_px_r   <= 31'(s_side.ax) * 31'(s_val);
      d_py_r   <= 31'(s_side.ay) * 31'(s_val);
    end
  end

  // Divide both products by the raw magnitude; quotients are magnitudes, so
  // truncation is toward zero once the sign is put back.
  logic        qx_vld, qy_vld;
  logic [15:0] qx, qy;
  jrd_side_t   q_side;
  logic        q_sy;

  jrd_div #(
    .NW (31),
    .DW (16),
    .QW (16),
    .TW ($bits(jrd_side_t))
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_vld_r),
    .dividend (d_px_r),
    .divisor  (d_mag_r),
    .in_tag   (d_side_r),
    .out_vld  (qx_vld),
    .quotient (qx),
    .out_tag  (q_side)
  );

  jrd_div #(
    .NW (31),
    .DW (16),
    .QW (16),
    .TW (1)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_vld_r),
    .dividend (d_py_r),
    .divisor  (d_mag_r),
    .in_tag   (d_side_r.sy),
    .out_vld  (qy_vld),
    .quotient (qy),
    .out_tag  (q_sy)
  );

  // Stage E: zero the axes of a sample inside the deadzone.
  logic        e_vld_r;
  logic        e_op_r, e_sx_r, e_sy_r;
  logic [31:0] e_rate_r;
  logic [15:0] e_qx_r, e_qy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= qx_vld && qy_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_op_r   <= q_side.op;
      e_sx_r   <= q_side.sx;
      e_sy_r   <= q_sy;
      e_rate_r <= q_side.rate;
      e_qx_r   <= q_side.pass ? qx : 16'd0;
      e_qy_r   <= q_side.pass ? qy : 16'd0;
    end
  end

  // Stage F: look scaling of the axis magnitudes.
  logic        f_vld_r;
  logic        f_op_r, f_sx_r, f_sy_r;
  logic [15:0] f_qx_r, f_qy_r;
  logic [47:0] f_lx_r, f_ly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_op_r <= e_op_r;
      f_sx_r <= e_sx_r;
      f_sy_r <= e_sy_r;
      f_qx_r <= e_qx_r;
      f_qy_r <= e_qy_r;
      f_lx_r <= 48'(e_qx_r) * 48'(e_rate_r);
      f_ly_r <= 48'(e_qy_r) * 48'(e_rate_r);
    end
  end

  // Stage G: apply signs and route to the move or look outputs. Forward is
  // the negated vertical axis, as is pitch.
  logic [20:0] lx_mag, ly_mag;
  logic signed [15:0] fwd_val, str_val;
  logic signed [20:0] yaw_val, pit_val;
  logic signed [15:0] out_fwd_r, out_str_r;
  logic signed [20:0] out_yaw_r, out_pit_r;

  assign lx_mag = 21'(f_lx_r >> LOOK_SHIFT);
  assign ly_mag = 21'(f_ly_r >> LOOK_SHIFT);

  always_comb begin
    fwd_val = f_sy_r ? $signed(f_qy_r) : $signed(16'(-f_qy_r));
    str_val = f_sx_r ? $signed(16'(-f_qx_r)) : $signed(f_qx_r);
    yaw_val = f_sx_r ? $signed(21'(-lx_mag)) : $signed(lx_mag);
    pit_val = f_sy_r ? $signed(ly_mag) : $signed(21'(-ly_mag));
    if (f_op_r) begin
      fwd_val = '0;
      str_val = '0;
    end else begin
      yaw_val = '0;
      pit_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_fwd_r <= fwd_val;
      out_str_r <= str_val;
      out_yaw_r <= yaw_val;
      out_pit_r <= pit_val;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.forward     = out_fwd_r;
  assign out_ch.strafe      = out_str_r;
  assign out_ch.yaw_delta   = out_yaw_r;
  assign out_ch.pitch_delta = out_pit_r;

endmodule
`default_nettype wire
